// ===== rtl/assert_macros.svh =====
// assertion helpers used by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst_n, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error(msg);

`endif

// ===== rtl/bcl_pkg.sv =====
// ----------------------------------------------------------------------------
// bcl_pkg
// Types and constants of the bpsk costas carrier loop.
// ----------------------------------------------------------------------------
`default_nettype none

package bcl_pkg;

    typedef enum logic [2:0] {
        K_STEP   = 3'd0,
        K_DEROT  = 3'd1,
        K_ADJUST = 3'd2,
        K_SEED   = 3'd3,
        K_CLEAR  = 3'd4
    } t_kind;

    typedef enum logic [1:0] {
        CFG_PHASE_GAIN = 2'd0,
        CFG_FREQ_GAIN  = 2'd1,
        CFG_LAMBDA     = 2'd2
    } t_cfg_idx;

    typedef enum logic [5:0] {
        S_IDLE, S_SQ0, S_SQ1, S_SQ2, S_SQ3,
        S_LG0, S_LG1, S_LG2, S_LG3, S_LG4,
        S_AV0, S_AV1, S_AV2, S_AV3, S_AV4,
        S_RI, S_CORD,
        S_RC0, S_RC1, S_RC2, S_RC3, S_RC4, S_RC5,
        S_E0, S_E1, S_E2,
        S_V0, S_V1, S_M0, S_M1, S_M2, S_M3,
        S_DONE
    } t_state;

    localparam logic [23:0] PHASE_GAIN_RST = 24'd1677722;
    localparam logic [23:0] FREQ_GAIN_RST  = 24'd83886;
    localparam logic [15:0] LAMBDA_RST     = 16'd655;

    localparam logic [23:0] CORDIC_K = 24'd10188014;
    localparam int          ATAN_LEN = 24;
    localparam int          AVG_FRAC = 36;

    // arctangent of 2^-k in turns times 2^32
    localparam logic [29:0] ATAN_TURNS [ATAN_LEN] = '{
        30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756,
        30'd42667331,  30'd21354465,  30'd10679838,  30'd5340245,
        30'd2670163,   30'd1335087,   30'd667544,    30'd333772,
        30'd166886,    30'd83443,     30'd41722,     30'd20861,
        30'd10430,     30'd5215,      30'd2608,      30'd1304,
        30'd652,       30'd326,       30'd163,       30'd81
    };

endpackage

`default_nettype wire

// ===== rtl/bcl_in_if.sv =====
// ----------------------------------------------------------------------------
// bcl_in_if
// Symbol channel into the carrier loop.
// ----------------------------------------------------------------------------
`default_nettype none

interface bcl_in_if #(parameter int SB = 16);
    logic                 valid;
    logic                 ready;
    logic [2:0]           kind;
    logic signed [SB-1:0] sample_i;
    logic signed [SB-1:0] sample_q;
    logic signed [SB-1:0] external_error;
    logic signed [31:0]   freq_seed;

    modport source (output valid, kind, sample_i, sample_q, external_error, freq_seed,
                    input ready);
    modport sink   (input valid, kind, sample_i, sample_q, external_error, freq_seed,
                    output ready);
endinterface

`default_nettype wire

// ===== rtl/bcl_out_if.sv =====
// ----------------------------------------------------------------------------
// bcl_out_if
// Result channel out of the carrier loop.
// ----------------------------------------------------------------------------
`default_nettype none

interface bcl_out_if #(parameter int SB = 16);
    logic                 valid;
    logic                 ready;
    logic signed [SB-1:0] out_i;
    logic signed [SB-1:0] out_q;
    logic signed [31:0]   loop_freq;
    logic [31:0]          loop_phase;
    logic signed [15:0]   coarse_freq;
    logic [39:0]          coarse_magnitude;

    modport source (output valid, out_i, out_q, loop_freq, loop_phase, coarse_freq,
                    coarse_magnitude, input ready);
    modport sink   (input valid, out_i, out_q, loop_freq, loop_phase, coarse_freq,
                    coarse_magnitude, output ready);
endinterface

`default_nettype wire

// ===== rtl/bpsk_costas_carrier_loop_top.sv =====
// ----------------------------------------------------------------------------
// bpsk_costas_carrier_loop_top
// Second order bpsk costas loop with squared-signal coarse frequency
// estimator, built around one shared multiplier and one cordic stage.
// ----------------------------------------------------------------------------
//  channel   dir  handshake        payload
//  i_sym     in   valid / ready    kind, sample_i, sample_q, external_error, freq_seed
//  o_res     out  valid / ready    out_i, out_q, loop_freq, loop_phase, coarse_freq,
//                                  coarse_magnitude
//  i_cfg_*   in   write enable     index, data (no read-back)
//
//  every kind ends in the coarse vectoring pass; a zero coarse average skips that pass
//  the shared multiplier and the single cordic stage run once per cycle
//  one transaction is in flight at a time; i_sym.ready is high only when idle
//  a finished result waits in the output register while the next one is taken
//  synchronous reset loads the default gains and clears the loop state at once
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module bpsk_costas_carrier_loop_top #(
    parameter int SAMPLE_BITS   = 16,
    parameter int CORDIC_STAGES = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    bcl_in_if.sink           i_sym,
    bcl_out_if.source        o_res,
    input  wire logic        i_cfg_wr_en,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [23:0] i_cfg_data
);

    localparam int SB  = SAMPLE_BITS;
    localparam int SW  = SB + 2;
    localparam int MW  = 27;
    localparam int PW  = 2 * MW;
    localparam int AC  = 68;
    localparam int DW  = 43;
    localparam int XW  = 52;
    localparam int ZW  = 34;
    localparam int AW  = 40;
    localparam int LOW = 26;
    localparam int NST = (CORDIC_STAGES > bcl_pkg::ATAN_LEN) ? bcl_pkg::ATAN_LEN
                                                             : CORDIC_STAGES;
    localparam int KW  = $clog2(NST);
    localparam int RSH = (2 * SB > bcl_pkg::AVG_FRAC) ? 2 * SB - bcl_pkg::AVG_FRAC : 0;
    localparam int LSH = (2 * SB > bcl_pkg::AVG_FRAC) ? 0 : bcl_pkg::AVG_FRAC - 2 * SB;

    localparam logic signed [ZW-1:0] HALF_TURN = ZW'(64'sd2147483648);
    localparam logic signed [AC-1:0] XG_MAX    = $signed(AC'(3) << 39);
    localparam logic signed [AC-1:0] MAG_MAX   = $signed((AC'(1) << AW) - AC'(1));
    localparam logic signed [AC-1:0] MAG_RND   = $signed(AC'(1) << 23);

    function automatic logic signed [AC-1:0] f_rnd(input logic signed [AC-1:0] v,
                                                   input int k);
        logic signed [AC-1:0] half;
        half = (k > 0) ? $signed(AC'(1) << (k - 1)) : '0;
        return (v + half) >>> k;
    endfunction

    function automatic logic signed [AC-1:0] f_sat(input logic signed [AC-1:0] v,
                                                   input int w);
        logic signed [AC-1:0] lim;
        lim = $signed(AC'(1) << (w - 1));
        if (v > lim - 1) return lim - 1;
        if (v < -lim) return -lim;
        return v;
    endfunction

    bcl_pkg::t_state r_state, n_state;

    logic [23:0]           r_phase_gain, r_freq_gain;
    logic [15:0]           r_lambda;
    logic [31:0]           r_phase;
    logic signed [31:0]    r_freq;
    logic signed [SW-1:0]  r_psi, r_psq, r_a, r_b;
    logic signed [AW-1:0]  r_avg_i, r_avg_q;

    logic [2:0]            r_kind;
    logic signed [SB-1:0]  r_si, r_sq, r_ext, r_oi, r_oq;
    logic signed [DW-1:0]  r_t0, r_t1, r_d;
    logic                  r_lane;
    logic signed [XW-1:0]  r_x, r_y;
    logic signed [ZW-1:0]  r_z;
    logic [KW-1:0]         r_k;
    logic                  r_vec;
    logic signed [PW-1:0]  r_prod;
    logic signed [AC-1:0]  r_acc;
    logic signed [15:0]    r_angle;
    logic [AW-1:0]         r_mag;

    logic                  r_ovalid;
    logic signed [SB-1:0]  r_o_i, r_o_q;
    logic signed [31:0]    r_o_freq;
    logic [31:0]           r_o_phase;
    logic signed [15:0]    r_o_angle;
    logic [AW-1:0]         r_o_mag;

    logic signed [MW-1:0]  m_a, m_b, e_val;
    logic signed [AC-1:0]  prod_ext, gain_t, xg;
    logic                  out_load, avg_zero, half_sel, c_pos;
    logic [31:0]           p_off, r_rot;
    logic signed [XW-1:0]  c_dx, c_dy, c_si8, c_ai8;
    logic signed [ZW-1:0]  c_at;

    assign i_sym.ready      = (r_state == bcl_pkg::S_IDLE);
    assign o_res.valid      = r_ovalid;
    assign o_res.out_i      = r_o_i;
    assign o_res.out_q      = r_o_q;
    assign o_res.loop_freq  = r_o_freq;
    assign o_res.loop_phase = r_o_phase;
    assign o_res.coarse_freq      = r_o_angle;
    assign o_res.coarse_magnitude = r_o_mag;

    assign prod_ext = AC'(r_prod);
    assign gain_t   = f_rnd(prod_ext <<< 8, SB - 1);
    assign out_load = (r_state == bcl_pkg::S_DONE) && (!r_ovalid || o_res.ready);
    assign avg_zero = (r_avg_i == '0) && (r_avg_q == '0);

    // phase error: external for adjust, else sign(i)*q of the derotated symbol
    assign e_val = (r_kind == bcl_pkg::K_ADJUST) ? MW'(r_ext)
                 : (r_oi[SB-1] ? -MW'(r_oq) : MW'(r_oq));

    // fold the phase into [-1/4, 1/4) turn, negating the vector for the far half
    assign p_off    = r_phase + 32'h4000_0000;
    assign half_sel = p_off[31];
    assign r_rot    = half_sel ? (r_phase - 32'h8000_0000) : r_phase;
    assign c_si8    = XW'(r_si) <<< 8;
    assign c_ai8    = XW'(r_avg_i) <<< 8;

    // shared cordic stage
    assign c_dx  = r_y >>> r_k;
    assign c_dy  = r_x >>> r_k;
    assign c_at  = ZW'(bcl_pkg::ATAN_TURNS[5'(r_k)]);
    assign c_pos = r_vec ? (r_y <= 0) : (r_z >= 0);

    always_comb begin
        n_state = r_state;
        m_a     = '0;
        m_b     = '0;
        unique case (r_state)
            bcl_pkg::S_IDLE: begin
                if (i_sym.valid) begin
                    unique case (i_sym.kind)
                        bcl_pkg::K_STEP:   n_state = bcl_pkg::S_SQ0;
                        bcl_pkg::K_DEROT:  n_state = bcl_pkg::S_RI;
                        bcl_pkg::K_ADJUST: n_state = bcl_pkg::S_E0;
                        default:           n_state = bcl_pkg::S_V0;
                    endcase
                end
            end
            bcl_pkg::S_SQ0: begin m_a = MW'(r_si); m_b = MW'(r_si); n_state = bcl_pkg::S_SQ1; end
            bcl_pkg::S_SQ1: begin m_a = MW'(r_sq); m_b = MW'(r_sq); n_state = bcl_pkg::S_SQ2; end
            bcl_pkg::S_SQ2: begin m_a = MW'(r_si); m_b = MW'(r_sq); n_state = bcl_pkg::S_SQ3; end
            bcl_pkg::S_SQ3: n_state = bcl_pkg::S_LG0;
            bcl_pkg::S_LG0: begin m_a = MW'(r_a); m_b = MW'(r_psi); n_state = bcl_pkg::S_LG1; end
            bcl_pkg::S_LG1: begin m_a = MW'(r_b); m_b = MW'(r_psq); n_state = bcl_pkg::S_LG2; end
            bcl_pkg::S_LG2: begin m_a = MW'(r_b); m_b = MW'(r_psi); n_state = bcl_pkg::S_LG3; end
            bcl_pkg::S_LG3: begin m_a = MW'(r_a); m_b = MW'(r_psq); n_state = bcl_pkg::S_LG4; end
            bcl_pkg::S_LG4: n_state = bcl_pkg::S_AV0;
            bcl_pkg::S_AV0: n_state = bcl_pkg::S_AV1;
            bcl_pkg::S_AV1: begin
                m_a = MW'({1'b0, r_d[LOW-1:0]});
                m_b = MW'({1'b0, r_lambda});
                n_state = bcl_pkg::S_AV2;
            end
            bcl_pkg::S_AV2: begin
                m_a = MW'($signed(r_d[DW-1:LOW]));
                m_b = MW'({1'b0, r_lambda});
                n_state = bcl_pkg::S_AV3;
            end
            bcl_pkg::S_AV3: n_state = bcl_pkg::S_AV4;
            bcl_pkg::S_AV4: n_state = r_lane ? bcl_pkg::S_RI : bcl_pkg::S_AV0;
            bcl_pkg::S_RI:  n_state = bcl_pkg::S_CORD;
            bcl_pkg::S_CORD: begin
                if (r_k == KW'(NST - 1))
                    n_state = r_vec ? bcl_pkg::S_V1 : bcl_pkg::S_RC0;
            end
            bcl_pkg::S_RC0, bcl_pkg::S_M0: begin
                m_a = MW'({1'b0, r_x[LOW-1:0]});
                m_b = MW'({1'b0, bcl_pkg::CORDIC_K});
                n_state = (r_state == bcl_pkg::S_RC0) ? bcl_pkg::S_RC1 : bcl_pkg::S_M1;
            end
            bcl_pkg::S_RC1, bcl_pkg::S_M1: begin
                m_a = MW'($signed(r_x[XW-1:LOW]));
                m_b = MW'({1'b0, bcl_pkg::CORDIC_K});
                n_state = (r_state == bcl_pkg::S_RC1) ? bcl_pkg::S_RC2 : bcl_pkg::S_M2;
            end
            bcl_pkg::S_RC2: begin
                m_a = MW'({1'b0, r_y[LOW-1:0]});
                m_b = MW'({1'b0, bcl_pkg::CORDIC_K});
                n_state = bcl_pkg::S_RC3;
            end
            bcl_pkg::S_RC3: begin
                m_a = MW'($signed(r_y[XW-1:LOW]));
                m_b = MW'({1'b0, bcl_pkg::CORDIC_K});
                n_state = bcl_pkg::S_RC4;
            end
            bcl_pkg::S_RC4: n_state = bcl_pkg::S_RC5;
            bcl_pkg::S_RC5: n_state = (r_kind == bcl_pkg::K_STEP) ? bcl_pkg::S_E0
                                                                 : bcl_pkg::S_V0;
            bcl_pkg::S_E0: begin
                m_a = MW'({1'b0, r_freq_gain}); m_b = e_val; n_state = bcl_pkg::S_E1;
            end
            bcl_pkg::S_E1: begin
                m_a = MW'({1'b0, r_phase_gain}); m_b = e_val; n_state = bcl_pkg::S_E2;
            end
            bcl_pkg::S_E2: n_state = bcl_pkg::S_V0;
            bcl_pkg::S_V0: n_state = avg_zero ? bcl_pkg::S_DONE : bcl_pkg::S_CORD;
            bcl_pkg::S_V1: n_state = bcl_pkg::S_M0;
            bcl_pkg::S_M2: n_state = bcl_pkg::S_M3;
            bcl_pkg::S_M3: n_state = bcl_pkg::S_DONE;
            bcl_pkg::S_DONE: begin
                if (!r_ovalid || o_res.ready) n_state = bcl_pkg::S_IDLE;
            end
            default: n_state = bcl_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= bcl_pkg::S_IDLE;
            r_ovalid     <= 1'b0;
            r_phase_gain <= bcl_pkg::PHASE_GAIN_RST;
            r_freq_gain  <= bcl_pkg::FREQ_GAIN_RST;
            r_lambda     <= bcl_pkg::LAMBDA_RST;
            r_phase      <= '0;
            r_freq       <= '0;
            r_psi        <= '0;
            r_psq        <= '0;
            r_avg_i      <= '0;
            r_avg_q      <= '0;
        end else begin
            r_state <= n_state;
            if (out_load) r_ovalid <= 1'b1;
            else if (o_res.ready) r_ovalid <= 1'b0;

            if (i_cfg_wr_en) begin
                unique case (i_cfg_index)
                    bcl_pkg::CFG_PHASE_GAIN: r_phase_gain <= i_cfg_data;
                    bcl_pkg::CFG_FREQ_GAIN:  r_freq_gain  <= i_cfg_data;
                    bcl_pkg::CFG_LAMBDA:     r_lambda     <= i_cfg_data[15:0];
                    default: ;
                endcase
            end

            case (r_state)
                bcl_pkg::S_IDLE: begin
                    if (i_sym.valid && i_sym.kind == bcl_pkg::K_SEED)
                        r_freq <= i_sym.freq_seed;
                    if (i_sym.valid && i_sym.kind == bcl_pkg::K_CLEAR) begin
                        r_phase <= '0;
                        r_freq  <= '0;
                        r_psi   <= '0;
                        r_psq   <= '0;
                        r_avg_i <= '0;
                        r_avg_q <= '0;
                    end
                end
                bcl_pkg::S_AV4: begin
                    if (r_lane) begin
                        r_avg_q <= AW'(f_sat(AC'(r_avg_q) + f_rnd(r_acc, 16), AW));
                        r_psi   <= r_a;
                        r_psq   <= r_b;
                    end else begin
                        r_avg_i <= AW'(f_sat(AC'(r_avg_i) + f_rnd(r_acc, 16), AW));
                    end
                end
                bcl_pkg::S_E1: r_freq <= 32'(f_sat(AC'(r_freq) + gain_t, 32));
                bcl_pkg::S_E2: begin
                    r_phase <= r_phase + ((r_kind == bcl_pkg::K_STEP) ? r_freq : 32'd0)
                             + gain_t[31:0];
                end
                default: ;
            endcase
        end
    end

    // datapath scratch, no reset needed
    always_ff @(posedge i_clk) begin
        r_prod <= m_a * m_b;
        case (r_state)
            bcl_pkg::S_IDLE: begin
                r_kind <= i_sym.kind;
                r_si   <= i_sym.sample_i;
                r_sq   <= i_sym.sample_q;
                r_ext  <= i_sym.external_error;
                r_oi   <= '0;
                r_oq   <= '0;
            end
            bcl_pkg::S_SQ1: r_acc <= prod_ext;
            bcl_pkg::S_SQ2: r_acc <= r_acc - prod_ext;
            bcl_pkg::S_SQ3: begin
                r_a <= SW'(f_sat(f_rnd(r_acc, SB - 2), SW));
                r_b <= SW'(f_sat(f_rnd(prod_ext <<< 1, SB - 2), SW));
            end
            bcl_pkg::S_LG1: r_acc <= prod_ext;
            bcl_pkg::S_LG2: r_t0 <= DW'(f_rnd(r_acc + prod_ext, RSH) <<< LSH);
            bcl_pkg::S_LG3: r_acc <= prod_ext;
            bcl_pkg::S_LG4: begin
                r_t1   <= DW'(f_rnd(r_acc - prod_ext, RSH) <<< LSH);
                r_lane <= 1'b0;
            end
            bcl_pkg::S_AV0: r_d <= r_lane ? (r_t1 - DW'(r_avg_q)) : (r_t0 - DW'(r_avg_i));
            bcl_pkg::S_AV2: r_acc <= prod_ext;
            bcl_pkg::S_AV3: r_acc <= r_acc + (prod_ext <<< LOW);
            bcl_pkg::S_AV4: r_lane <= 1'b1;
            bcl_pkg::S_RI: begin
                r_x   <= half_sel ? -c_si8 : c_si8;
                r_y   <= half_sel ? -(XW'(r_sq) <<< 8) : (XW'(r_sq) <<< 8);
                r_z   <= -ZW'($signed(r_rot));
                r_k   <= '0;
                r_vec <= 1'b0;
            end
            bcl_pkg::S_CORD: begin
                if (c_pos) begin
                    r_x <= r_x - c_dx;
                    r_y <= r_y + c_dy;
                    r_z <= r_z - c_at;
                end else begin
                    r_x <= r_x + c_dx;
                    r_y <= r_y - c_dy;
                    r_z <= r_z + c_at;
                end
                r_k <= r_k + 1'b1;
            end
            bcl_pkg::S_RC1, bcl_pkg::S_M1: r_acc <= prod_ext;
            bcl_pkg::S_RC2, bcl_pkg::S_RC4, bcl_pkg::S_M2: r_acc <= r_acc + (prod_ext <<< LOW);
            bcl_pkg::S_RC3: begin
                r_oi  <= SB'(f_sat(f_rnd(r_acc, 32), SB));
                r_acc <= prod_ext;
            end
            bcl_pkg::S_RC5: r_oq <= SB'(f_sat(f_rnd(r_acc, 32), SB));
            bcl_pkg::S_V0: begin
                r_angle <= '0;
                r_mag   <= '0;
                // left half plane: start from a half turn, sign taken from y
                if (r_avg_i[AW-1]) begin
                    r_x <= -c_ai8;
                    r_y <= -(XW'(r_avg_q) <<< 8);
                    r_z <= r_avg_q[AW-1] ? -HALF_TURN : HALF_TURN;
                end else begin
                    r_x <= c_ai8;
                    r_y <= XW'(r_avg_q) <<< 8;
                    r_z <= '0;
                end
                r_k   <= '0;
                r_vec <= 1'b1;
            end
            bcl_pkg::S_V1: begin
                r_angle <= 16'(f_sat(f_rnd(AC'(r_z), 17), 16));
                if (xg < 0)
                    r_x <= '0;
                else if (xg > XG_MAX)
                    r_x <= XW'(XG_MAX);
                else
                    r_x <= XW'(xg);
            end
            bcl_pkg::S_M3: begin
                if (((r_acc + MAG_RND) >>> 24) > MAG_MAX)
                    r_mag <= AW'(MAG_MAX);
                else
                    r_mag <= AW'((r_acc + MAG_RND) >>> 24);
            end
            default: ;
        endcase
        if (out_load) begin
            r_o_i     <= r_oi;
            r_o_q     <= r_oq;
            r_o_freq  <= r_freq;
            r_o_phase <= r_phase;
            r_o_angle <= r_angle;
            r_o_mag   <= r_mag;
        end
    end

    assign xg = f_rnd(AC'(r_x), 8);

    `ASSERT_NEXT(a_busy_after_take, i_clk, i_rst_n, i_sym.valid && i_sym.ready,
        r_state != bcl_pkg::S_IDLE, "block still ready after taking a transaction")
    `ASSERT_NEXT(a_result_loaded, i_clk, i_rst_n, out_load,
        r_ovalid && r_state == bcl_pkg::S_IDLE, "finished result not presented")
    `ASSERT_IMPLIES(a_cordic_bound, i_clk, i_rst_n, r_state == bcl_pkg::S_CORD,
        r_k <= KW'(NST - 1), "cordic stage count out of range")
    `ASSERT_IMPLIES(a_no_sample_zero, i_clk, i_rst_n,
        r_state == bcl_pkg::S_DONE && r_kind != bcl_pkg::K_STEP
            && r_kind != bcl_pkg::K_DEROT,
        r_oi == '0 && r_oq == '0, "derotated output set for a non-sample kind")

endmodule

`default_nettype wire
